// File: rtl/core/imask_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imask_pkg;

  localparam int MAX_RULES_DEF = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_CLEAR = 2'd0;
  localparam op_t OP_ADD   = 2'd1;
  localparam op_t OP_MASK  = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BETWEEN = 2'd0;
  localparam kind_t KIND_BELOW   = 2'd1;
  localparam kind_t KIND_ABOVE   = 2'd2;

  localparam logic signed [31:0] NULL_CODE = 32'sh8000_0000;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] value;
    logic signed [31:0] bound_a;
    logic signed [31:0] bound_b;
    kind_t              rule_kind;
    logic               row_end;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pixel_out;
    logic               is_null;
    logic               row_end_out;
  } out_t;

  // One beat moving down the rule chain: a pixel under test or a rule to store.
  // For a pixel, a holds the value; for a rule, a/b are the ordered bounds.
  typedef struct packed {
    logic               valid;
    logic               is_add;
    logic signed [31:0] a;
    logic signed [31:0] b;
    kind_t              kind;
    logic               row_end;
    logic               hit;
  } beat_t;

endpackage

`default_nettype wire

// File: rtl/core/imask_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module imask_cell #(
  parameter int MAX_RULES = imask_pkg::MAX_RULES_DEF,
  parameter int CELL_ID   = 0,
  localparam int CW       = $clog2(MAX_RULES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire imask_pkg::beat_t  beat_i,
  input  wire logic [CW-1:0]     idx_i,
  input  wire logic [CW-1:0]     cnt_i,
  output imask_pkg::beat_t       beat_o,
  output logic [CW-1:0]          idx_o,
  output logic [CW-1:0]          cnt_o
);

  logic signed [31:0] lo_r;
  logic signed [31:0] hi_r;
  imask_pkg::kind_t   kind_r;
  imask_pkg::beat_t   beat_r;
  imask_pkg::beat_t   beat_nxt;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      cnt_r;
  logic               match;
  logic               store;

  assign store = adv && beat_i.valid && beat_i.is_add && (idx_i == CW'(CELL_ID));

  always_comb begin
    unique case (kind_r)
      imask_pkg::KIND_BELOW: match = beat_i.a <= lo_r;
      imask_pkg::KIND_ABOVE: match = beat_i.a >= hi_r;
      default:               match = (beat_i.a >= lo_r) && (beat_i.a <= hi_r);
    endcase
  end

  always_comb begin
    beat_nxt = beat_i;
    // only rules below the count seen at intake take part
    if (!beat_i.is_add && (CW'(CELL_ID) < cnt_i) && match) begin
      beat_nxt.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      lo_r   <= beat_i.a;
      hi_r   <= beat_i.b;
      kind_r <= beat_i.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (adv) begin
      beat_r <= beat_nxt;
      idx_r  <= idx_i;
      cnt_r  <= cnt_i;
    end
  end

  assign beat_o = beat_r;
  assign idx_o  = idx_r;
  assign cnt_o  = cnt_r;

endmodule

`default_nettype wire

// File: rtl/core/integer_interval_pixel_mask.sv
`timescale 1ns / 1ps
`default_nettype none

// Interval pixel mask. Takes one beat per cycle: clear, add-rule or mask-pixel.
// Each of the MAX_RULES cells holds one rule; a pixel walks the chain one cell
// per cycle unless the chain is stalled, registered in each cell, and the block
// sustains one beat per cycle while the result side keeps up. Rule
// writes travel the same chain, so every pixel sees exactly the rules added
// before it. A stall while a result waits at the tail freezes the whole chain
// and stalls the input in the same cycle.
module integer_interval_pixel_mask #(
  parameter int MAX_RULES = imask_pkg::MAX_RULES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire imask_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output imask_pkg::out_t     out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_wdata
);

  localparam int CW = $clog2(MAX_RULES + 1);

  logic               invert_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;
  logic               adv;
  logic               in_accept;
  logic               full;
  logic               keep;
  logic signed [31:0] lo;
  logic signed [31:0] hi;

  imask_pkg::beat_t   chain [MAX_RULES+1];
  logic [CW-1:0]      idx_c [MAX_RULES+1];
  logic [CW-1:0]      cnt_c [MAX_RULES+1];

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;
  assign full      = (cnt_r == CW'(MAX_RULES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      invert_r <= cfg_wdata;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_accept) begin
      priority if (in_data.operation == imask_pkg::OP_CLEAR) begin
        cnt_nxt = '0;
      end else if (in_data.operation == imask_pkg::OP_ADD && !full) begin
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        cnt_nxt = cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    if (in_data.bound_a <= in_data.bound_b) begin
      lo = in_data.bound_a;
      hi = in_data.bound_b;
    end else begin
      lo = in_data.bound_b;
      hi = in_data.bound_a;
    end
  end

  // intake beat; clears act on the count alone and never enter the chain
  always_comb begin
    chain[0].valid   = in_accept && ((in_data.operation == imask_pkg::OP_MASK) ||
                       (in_data.operation == imask_pkg::OP_ADD && !full));
    chain[0].is_add  = (in_data.operation == imask_pkg::OP_ADD);
    chain[0].a       = chain[0].is_add ? lo : in_data.value;
    chain[0].b       = hi;
    chain[0].kind    = in_data.rule_kind;
    chain[0].row_end = in_data.row_end;
    chain[0].hit     = 1'b0;
  end

  assign idx_c[0] = cnt_r;
  assign cnt_c[0] = cnt_r;

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    imask_cell #(
      .MAX_RULES (MAX_RULES),
      .CELL_ID   (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .beat_i (chain[i]),
      .idx_i  (idx_c[i]),
      .cnt_i  (cnt_c[i]),
      .beat_o (chain[i+1]),
      .idx_o  (idx_c[i+1]),
      .cnt_o  (cnt_c[i+1])
    );
  end

  // rule beats drain off the tail silently
  assign out_valid = chain[MAX_RULES].valid && !chain[MAX_RULES].is_add;
  assign keep      = (cnt_c[MAX_RULES] == '0) || (invert_r ^ chain[MAX_RULES].hit);

  always_comb begin
    out_data.pixel_out   = keep ? chain[MAX_RULES].a : imask_pkg::NULL_CODE;
    out_data.is_null     = !keep;
    out_data.row_end_out = chain[MAX_RULES].row_end;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RULES))
    else $error("rule count past table size");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.operation == imask_pkg::OP_CLEAR |=> cnt_r == '0)
    else $error("clear did not empty the table");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.operation == imask_pkg::OP_ADD && full |=> full)
    else $error("add on full table changed the count");

  a_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_null |-> out_data.pixel_out == imask_pkg::NULL_CODE)
    else $error("dropped pixel without null code");

endmodule

`default_nettype wire

// File: tb/tb_integer_interval_pixel_mask.sv
`timescale 1ns / 1ps

module tb_integer_interval_pixel_mask;

  localparam int NRULES = imask_pkg::MAX_RULES_DEF;
  localparam int LIMIT = 300000;
  localparam imask_pkg::op_t OP_UNUSED = 2'd3;
  localparam imask_pkg::kind_t KIND_SPARE = 2'd3;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  imask_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  imask_pkg::out_t out_data;
  logic cfg_we;
  logic cfg_wdata;

  integer_interval_pixel_mask DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // rule table as the pixels see it
  logic signed [31:0] lo_tab [NRULES];
  logic signed [31:0] hi_tab [NRULES];
  imask_pkg::kind_t   kind_tab [NRULES];
  int                 rule_cnt = 0;
  logic               inv_model = 1'b0;

  imask_pkg::in_t  pend_q [$];
  imask_pkg::out_t pixel_q [$];
  logic signed [31:0] probe_vals [$];

  int   n_queued = 0;
  int   n_err = 0;
  int   n_pix = 0;
  int   n_drop = 0;
  int   n_rules = 0;
  int   n_full = 0;
  int   n_checked = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   cycles = 0;
  logic quiet = 1'b0;

  task automatic report_mismatch(input string what);
    n_err++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void mask_predict(input imask_pkg::in_t b);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic hit;
    logic keep;
    imask_pkg::out_t r;
    case (b.operation)
      imask_pkg::OP_CLEAR: rule_cnt = 0;
      imask_pkg::OP_ADD: begin
        if (rule_cnt < NRULES) begin
          lo = (b.bound_a <= b.bound_b) ? b.bound_a : b.bound_b;
          hi = (b.bound_a >= b.bound_b) ? b.bound_a : b.bound_b;
          lo_tab[rule_cnt] = lo;
          hi_tab[rule_cnt] = hi;
          kind_tab[rule_cnt] = b.rule_kind;
          rule_cnt++;
          n_rules++;
        end else begin
          n_full++;
        end
      end
      imask_pkg::OP_MASK: begin
        hit = 1'b0;
        for (int i = 0; i < rule_cnt; i++) begin
          case (kind_tab[i])
            imask_pkg::KIND_BELOW: if (b.value <= lo_tab[i]) hit = 1'b1;
            imask_pkg::KIND_ABOVE: if (b.value >= hi_tab[i]) hit = 1'b1;
            default: if (b.value >= lo_tab[i] && b.value <= hi_tab[i]) hit = 1'b1;
          endcase
        end
        keep = (rule_cnt == 0) ? 1'b1 : (inv_model ? !hit : hit);
        r.pixel_out = keep ? b.value : imask_pkg::NULL_CODE;
        r.is_null = !keep;
        r.row_end_out = b.row_end;
        pixel_q.push_back(r);
        n_pix++;
        if (!keep) n_drop++;
      end
      default: ;  // unused op: no effect
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) mask_predict(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          if (!quiet && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 5) - 1;
            in_valid <= 1'b0;
          end else begin
            in_data <= pend_q.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    imask_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat pixel=%h", out_data.pixel_out));
        end else begin
          want = pixel_q.pop_front();
          n_checked++;
          if (out_data.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("pixel_out got %h want %h",
                                      out_data.pixel_out, want.pixel_out));
          if (out_data.is_null !== want.is_null)
            report_mismatch($sformatf("is_null got %b want %b",
                                      out_data.is_null, want.is_null));
          if (out_data.row_end_out !== want.row_end_out)
            report_mismatch($sformatf("row_end_out got %b want %b",
                                      out_data.row_end_out, want.row_end_out));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pixel_q.size());
      $display("tb_integer_interval_pixel_mask: FAIL");
      $finish;
    end
  end

  function automatic imask_pkg::in_t rand_beat(input imask_pkg::op_t op);
    imask_pkg::in_t b;
    b.operation = op;
    b.value = $urandom;
    b.bound_a = $urandom;
    b.bound_b = $urandom;
    b.rule_kind = imask_pkg::kind_t'($urandom_range(0, 3));
    b.row_end = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic imask_pkg::in_t dir_beat(input imask_pkg::op_t op,
                                              input logic signed [31:0] v,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] bb,
                                              input imask_pkg::kind_t kind,
                                              input logic re);
    imask_pkg::in_t b;
    b = rand_beat(op);
    b.value = v;
    b.bound_a = a;
    b.bound_b = bb;
    b.rule_kind = kind;
    b.row_end = re;
    return b;
  endfunction

  task automatic queue_beat(input imask_pkg::in_t b);
    pend_q.push_back(b);
    n_queued++;
  endtask

  // an optional clear, a batch of rules, then pixels, many aimed at their bounds
  task automatic gen_sequence();
    imask_pkg::in_t b;
    int n_add;
    int n_px;
    probe_vals.delete();
    if ($urandom_range(0, 9) != 0) queue_beat(rand_beat(imask_pkg::OP_CLEAR));
    n_add = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 6);
    repeat (n_add) begin
      b = rand_beat(imask_pkg::OP_ADD);
      if ($urandom_range(0, 2) != 0) begin
        b.bound_a = int'($urandom_range(0, 400)) - 200;
        b.bound_b = int'($urandom_range(0, 400)) - 200;
      end
      probe_vals.push_back(b.bound_a);
      probe_vals.push_back(b.bound_b);
      queue_beat(b);
    end
    n_px = $urandom_range(2, 12);
    repeat (n_px) begin
      b = rand_beat(imask_pkg::OP_MASK);
      case ($urandom_range(0, 5))
        0: ;
        1: b.value = $urandom_range(0, 1) ? VMIN : VMAX;
        2: b.value = int'($urandom_range(0, 440)) - 220;
        default: begin
          if (probe_vals.size() != 0)
            b.value = probe_vals[$urandom_range(0, probe_vals.size() - 1)]
                      + int'($urandom_range(0, 2)) - 1;
        end
      endcase
      if ($urandom_range(0, 19) == 0) b.operation = OP_UNUSED;
      queue_beat(b);
    end
  endtask

  task automatic fill_random(input int target);
    int base;
    base = n_queued;
    while (n_queued - base < target) gen_sequence();
  endtask

  // all beats taken, all results back, chain flushed
  task automatic wait_idle();
    do @(negedge clk); while (pend_q.size() != 0 || in_valid || pixel_q.size() != 0);
    repeat (NRULES + 8) @(posedge clk);
  endtask

  task automatic write_invert(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    inv_model = v;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_invert(1'b0);
    @(negedge clk);
    // empty table keeps all, null-valued pixel stays non-null
    queue_beat(dir_beat(imask_pkg::OP_MASK, VMIN, 0, 0, imask_pkg::KIND_BETWEEN, 1'b1));
    queue_beat(dir_beat(imask_pkg::OP_MASK, VMAX, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    // bounds given high-then-low
    queue_beat(dir_beat(imask_pkg::OP_ADD, 0, 100, -100, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, -100, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 100, 0, 0, imask_pkg::KIND_BETWEEN, 1'b1));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 101, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, -101, 0, 0, imask_pkg::KIND_BETWEEN, 1'b1));
    queue_beat(dir_beat(imask_pkg::OP_ADD, 0, -5000, VMIN, imask_pkg::KIND_BELOW, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, VMIN, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_ADD, 0, VMAX, 0, imask_pkg::KIND_ABOVE, 1'b1));
    queue_beat(dir_beat(imask_pkg::OP_MASK, VMAX, 0, 0, imask_pkg::KIND_BETWEEN, 1'b1));
    queue_beat(dir_beat(imask_pkg::OP_ADD, 0, 2000, 1000, KIND_SPARE, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 1500, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 2001, 0, 0, imask_pkg::KIND_BETWEEN, 1'b1));
    queue_beat(dir_beat(OP_UNUSED, 1500, 3, -3, imask_pkg::KIND_ABOVE, 1'b1));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 1500, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_CLEAR, 0, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 2001, 0, 0, imask_pkg::KIND_BETWEEN, 1'b1));
    fill_random(400);
    wait_idle();

    write_invert(1'b1);
    @(negedge clk);
    queue_beat(dir_beat(imask_pkg::OP_ADD, 0, -10, 10, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 0, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 11, 0, 0, imask_pkg::KIND_BETWEEN, 1'b1));
    queue_beat(dir_beat(imask_pkg::OP_CLEAR, 0, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    queue_beat(dir_beat(imask_pkg::OP_MASK, 0, 0, 0, imask_pkg::KIND_BETWEEN, 1'b0));
    fill_random(400);
    wait_idle();

    write_invert(1'b0);
    @(negedge clk);
    fill_random(300);
    wait_idle();

    // last stretch at full rate, no idling on either side
    write_invert(1'b1);
    @(negedge clk);
    quiet = 1'b1;
    fill_random(350);
    wait_idle();
    repeat (2 * NRULES) @(posedge clk);

    $display("covered %0d beats over 4 invert settings: %0d pixels checked, %0d dropped",
             n_queued, n_checked, n_drop);
    $display("rules stored %0d, adds refused on a full table %0d", n_rules, n_full);
    if (n_err == 0) begin
      $display("tb_integer_interval_pixel_mask: PASS");
    end else begin
      $display("%0d mismatches", n_err);
      $display("tb_integer_interval_pixel_mask: FAIL");
    end
    $finish;
  end

endmodule
